>>> rtl/fbm_value_noise_3d_unit_macros.svh
// Assertion macros shared by the noise unit.
`ifndef FBM_VALUE_NOISE_3D_UNIT_MACROS_SVH
`define FBM_VALUE_NOISE_3D_UNIT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define FVN_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define FVN_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/fvn_pkg.sv
package fvn_pkg;

  localparam int NUM_OCT     = 4;
  localparam int FRAC        = 16;
  localparam int CELL_STAGES = 14;
  localparam int SUM_W       = 27;
  localparam int VAL_W       = 26;
  localparam int WT_W        = 17;
  localparam int OUT_W       = 18;

  localparam logic [31:0] GOLD   = 32'h9e3779b9;
  localparam logic [31:0] MIX_K1 = 32'h7feb352d;
  localparam logic [31:0] MIX_K2 = 32'h846ca68b;
  localparam logic [31:0] HASH_KX = 32'h8da6b343;
  localparam logic [31:0] HASH_KY = 32'hd8163841;
  localparam logic [31:0] HASH_KZ = 32'hcb1ab31f;

  typedef struct packed {
    logic                    vld;
    logic [2:0][31:0]        pos;
    logic signed [SUM_W-1:0] sum;
  } cell_bus_t;

  function automatic logic [23:0] oct_scale(input logic [2:0] idx);
    logic [23:0] s;
    case (idx)
      3'd0: s = 24'd65536;
      3'd1: s = 24'd132383;
      3'd2: s = 24'd267413;
      3'd3: s = 24'd540174;
      3'd4: s = 24'd1091152;
      3'd5: s = 24'd2204128;
      3'd6: s = 24'd4452338;
      default: s = 24'd8993723;
    endcase
    return s;
  endfunction

  function automatic logic [31:0] mix_a(input logic [31:0] a, input logic [31:0] b);
    logic [31:0] v;
    v = a ^ (b + GOLD + (a << 6) + (a >> 2));
    v = v ^ (v >> 16);
    return v * MIX_K1;
  endfunction

  function automatic logic [31:0] mix_b(input logic [31:0] m);
    logic [31:0] v;
    v = m ^ (m >> 15);
    return v * MIX_K2;
  endfunction

  function automatic logic [31:0] mix_end(input logic [31:0] m);
    return m ^ (m >> 16);
  endfunction

endpackage

>>> rtl/fbm_value_noise_3d_unit.sv
// Each input point passes through the four octave cells in turn and then the output register.
// Throughput: one point per cycle while the output is not stalled; the four octave cells form a single pipeline.
// A stalled result freezes the whole pipeline until it is taken.
// Reset is synchronous and active low; it clears valid flags and sets the seed to zero.
module fbm_value_noise_3d_unit (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [31:0]                in_pos_x,
  input  logic signed [31:0]                in_pos_y,
  input  logic signed [31:0]                in_pos_z,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [fvn_pkg::OUT_W-1:0]  out_noise_value,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [2:0]                        cfg_paddr,
  input  logic [31:0]                       cfg_pwdata,
  output logic [31:0]                       cfg_prdata,
  output logic                              cfg_pready
);
  import fvn_pkg::*;

`include "fbm_value_noise_3d_unit_macros.svh"

  logic [31:0]              seed_r;
  logic                     out_valid_r;
  logic signed [OUT_W-1:0]  out_value_r;
  logic signed [OUT_W-1:0]  out_value_nxt;
  logic                     en;
  cell_bus_t                bus [NUM_OCT+1];
  logic signed [SUM_W-9:0]  scaled;

  assign en         = !out_valid_r || out_ready;
  assign in_ready   = en;
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr[2] == 1'b0) ? seed_r : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= 32'd0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0) begin
      seed_r <= cfg_pwdata;
    end
  end

  assign bus[0].vld = in_valid;
  assign bus[0].pos = {in_pos_z, in_pos_y, in_pos_x};
  assign bus[0].sum = '0;

  for (genvar g = 0; g < NUM_OCT; g++) begin : g_cell
    fvn_octave_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .en      (en),
      .oct_idx (3'(g)),
      .seed    (seed_r),
      .bus_i   (bus[g]),
      .bus_o   (bus[g+1])
    );
  end

  always_comb begin
    scaled = (SUM_W-8)'(bus[NUM_OCT].sum >>> (24 - FRAC));
    if (scaled > (SUM_W-8)'(131071)) begin
      out_value_nxt = OUT_W'(131071);
    end else if (scaled < -(SUM_W-8)'(131072)) begin
      out_value_nxt = -OUT_W'(131072);
    end else begin
      out_value_nxt = OUT_W'(scaled);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= bus[NUM_OCT].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_value_r <= out_value_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_noise_value = out_value_r;

  `FVN_ASSERT_NOW(a_range, out_valid_r, (out_value_r >= -OUT_W'(65536) && out_value_r <= OUT_W'(65536)), "noise result out of range")
  `FVN_ASSERT_NEXT(a_freeze, !en, $stable(bus[NUM_OCT]), "pipeline moved during stall")
  `FVN_ASSERT_NEXT(a_seed, cfg_psel && cfg_penable && cfg_pwrite && cfg_paddr[2] == 1'b0, seed_r == $past(cfg_pwdata), "seed write lost")

endmodule

>>> rtl/fvn_octave_cell.sv
module fvn_octave_cell (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic [2:0]         oct_idx,
  input  logic [31:0]        seed,
  input  fvn_pkg::cell_bus_t bus_i,
  output fvn_pkg::cell_bus_t bus_o
);
  import fvn_pkg::*;

  localparam int NST = CELL_STAGES;

  logic                    vld_r [NST];
  logic [2:0][31:0]        pos_r [NST];
  logic signed [SUM_W-1:0] sum_r [NST];
  logic [2:0][WT_W-1:0]    wt_r  [NST];

  logic signed [56:0]      p1_r [3];
  logic [31:0]             tt2_r [3];
  logic [15:0]             t2_r [3];
  logic [31:0]             mc2_r [3][2];
  logic [33:0]             wp3_r [3];
  logic [31:0]             fa3_r [2];
  logic [31:0]             mcy3_r [2];
  logic [31:0]             mcz3_r [2];
  logic [31:0]             fb4_r [2];
  logic [31:0]             mcy4_r [2];
  logic [31:0]             mcz4_r [2];
  logic [31:0]             fa5_r [4];
  logic [31:0]             mcz5_r [2];
  logic [31:0]             fb6_r [4];
  logic [31:0]             mcz6_r [2];
  logic [31:0]             fa7_r [8];
  logic [31:0]             fb8_r [8];
  logic signed [44:0]      d9_r [4];
  logic signed [VAL_W-1:0] a9_r [4];
  logic signed [VAL_W-1:0] b10_r [4];
  logic signed [44:0]      d11_r [2];
  logic signed [VAL_W-1:0] a11_r [2];
  logic signed [VAL_W-1:0] b12_r [2];
  logic signed [44:0]      d13_r;
  logic signed [VAL_W-1:0] a13_r;

  logic [31:0]             oct_seed;
  logic [23:0]             scale;

  assign oct_seed = seed ^ 32'(GOLD * {28'd0, {1'b0, oct_idx} + 4'd1});
  assign scale    = oct_scale(oct_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NST; k++) begin
        vld_r[k] <= 1'b0;
      end
    end else if (en) begin
      vld_r[0] <= bus_i.vld;
      for (int k = 1; k < NST; k++) begin
        vld_r[k] <= vld_r[k-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    logic signed [56:0]      pe;
    logic signed [56:0]      se;
    logic [31:0]             cc;
    logic [15:0]             tv;
    logic [17:0]             kv;
    logic signed [VAL_W-1:0] cv [8];
    logic signed [VAL_W:0]   df;
    logic signed [44:0]      de;
    logic signed [44:0]      we;
    logic signed [VAL_W-1:0] nv;
    logic signed [SUM_W-1:0] ne;
    logic [31:0]             hf;
    if (en) begin
      pos_r[0] <= bus_i.pos;
      sum_r[0] <= bus_i.sum;
      for (int k = 1; k < NST; k++) begin
        pos_r[k] <= pos_r[k-1];
      end
      for (int k = 1; k < NST-1; k++) begin
        sum_r[k] <= sum_r[k-1];
      end
      for (int k = 4; k < NST; k++) begin
        wt_r[k] <= wt_r[k-1];
      end

      for (int a = 0; a < 3; a++) begin
        pe = 57'($signed(bus_i.pos[a]));
        se = $signed({33'd0, scale});
        p1_r[a] <= pe * se;
      end

      for (int a = 0; a < 3; a++) begin
        cc = 32'(p1_r[a] >>> 32);
        tv = p1_r[a][31:16];
        t2_r[a]  <= tv;
        tt2_r[a] <= {16'd0, tv} * {16'd0, tv};
        case (a)
          0: begin
            mc2_r[a][0] <= cc * HASH_KX;
            mc2_r[a][1] <= cc * HASH_KX + HASH_KX;
          end
          1: begin
            mc2_r[a][0] <= cc * HASH_KY;
            mc2_r[a][1] <= cc * HASH_KY + HASH_KY;
          end
          default: begin
            mc2_r[a][0] <= cc * HASH_KZ;
            mc2_r[a][1] <= cc * HASH_KZ + HASH_KZ;
          end
        endcase
      end

      for (int a = 0; a < 3; a++) begin
        kv = 18'd196608 - {1'b0, t2_r[a], 1'b0};
        wp3_r[a] <= {18'd0, tt2_r[a][31:16]} * {16'd0, kv};
      end
      for (int j = 0; j < 2; j++) begin
        fa3_r[j]  <= mix_a(oct_seed, mc2_r[0][j]);
        mcy3_r[j] <= mc2_r[1][j];
        mcz3_r[j] <= mc2_r[2][j];
      end

      for (int a = 0; a < 3; a++) begin
        wt_r[3][a] <= WT_W'(wp3_r[a] >> FRAC);
      end
      for (int j = 0; j < 2; j++) begin
        fb4_r[j]  <= mix_b(fa3_r[j]);
        mcy4_r[j] <= mcy3_r[j];
        mcz4_r[j] <= mcz3_r[j];
      end

      for (int j = 0; j < 4; j++) begin
        fa5_r[j] <= mix_a(mix_end(fb4_r[j%2]), mcy4_r[j/2]);
      end
      for (int j = 0; j < 2; j++) begin
        mcz5_r[j] <= mcz4_r[j];
        mcz6_r[j] <= mcz5_r[j];
      end

      for (int j = 0; j < 4; j++) begin
        fb6_r[j] <= mix_b(fa5_r[j]);
      end

      for (int j = 0; j < 8; j++) begin
        fa7_r[j] <= mix_a(mix_end(fb6_r[j%4]), mcz6_r[j/4]);
      end

      for (int j = 0; j < 8; j++) begin
        fb8_r[j] <= mix_b(fa7_r[j]);
      end

      for (int j = 0; j < 8; j++) begin
        hf = mix_end(fb8_r[j]);
        cv[j] = $signed({1'b0, hf[31:8], 1'b0}) - $signed(26'd16777216);
      end
      for (int g = 0; g < 4; g++) begin
        df = (VAL_W+1)'(cv[2*g+1]) - (VAL_W+1)'(cv[2*g]);
        de = 45'(df);
        we = $signed({28'd0, wt_r[7][0]});
        d9_r[g] <= de * we;
        a9_r[g] <= cv[2*g];
      end

      for (int g = 0; g < 4; g++) begin
        b10_r[g] <= a9_r[g] + VAL_W'(d9_r[g] >>> FRAC);
      end

      for (int h = 0; h < 2; h++) begin
        df = (VAL_W+1)'(b10_r[2*h+1]) - (VAL_W+1)'(b10_r[2*h]);
        de = 45'(df);
        we = $signed({28'd0, wt_r[9][1]});
        d11_r[h] <= de * we;
        a11_r[h] <= b10_r[2*h];
      end

      for (int h = 0; h < 2; h++) begin
        b12_r[h] <= a11_r[h] + VAL_W'(d11_r[h] >>> FRAC);
      end

      df = (VAL_W+1)'(b12_r[1]) - (VAL_W+1)'(b12_r[0]);
      de = 45'(df);
      we = $signed({28'd0, wt_r[11][2]});
      d13_r <= de * we;
      a13_r <= b12_r[0];

      nv = a13_r + VAL_W'(d13_r >>> FRAC);
      ne = SUM_W'(nv);
      sum_r[NST-1] <= sum_r[NST-2] + (ne >>> ({1'b0, oct_idx} + 4'd1));
    end
  end

  assign bus_o.vld = vld_r[NST-1];
  assign bus_o.pos = pos_r[NST-1];
  assign bus_o.sum = sum_r[NST-1];

endmodule

>>> tb/fbm_value_noise_3d_unit_test.sv
`timescale 1ns / 1ps

module fbm_value_noise_3d_unit_test;
  import fvn_pkg::*;

  typedef struct {
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } point_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_ready;
  logic signed [31:0] in_pos_x, in_pos_y, in_pos_z;
  logic out_valid;
  logic out_ready;
  logic signed [OUT_W-1:0] out_noise_value;
  logic cfg_psel, cfg_penable, cfg_pwrite;
  logic [2:0] cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic cfg_pready;

  localparam logic [2:0] ADDR_SEED = 3'd0;
  localparam logic [2:0] ADDR_BAD = 3'd4;
  localparam int PIPE_LAT = 57;

  fbm_value_noise_3d_unit dut (.*);

  point_t pending_points[$];
  logic [OUT_W-1:0] expected_noise[$];
  logic [31:0] seed_model;
  int errors;
  int hold_count;
  bit quiet_mode;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint fshift(longint v, int n);
    return v >>> n;
  endfunction

  function automatic logic [31:0] mix(logic [31:0] x);
    x = x ^ (x >> 16);
    x = x * 32'h7feb352d;
    x = x ^ (x >> 15);
    x = x * 32'h846ca68b;
    x = x ^ (x >> 16);
    return x;
  endfunction

  function automatic logic [31:0] fold(logic [31:0] a, logic [31:0] b);
    return mix(a ^ (b + 32'h9e3779b9 + (a << 6) + (a >> 2)));
  endfunction

  function automatic longint lattice_value(logic [31:0] cx, logic [31:0] cy,
                                           logic [31:0] cz, logic [31:0] sd);
    logic [31:0] h;
    h = fold(sd, cx * 32'h8da6b343);
    h = fold(h, cy * 32'hd8163841);
    h = fold(h, cz * 32'hcb1ab31f);
    return 2 * longint'({40'd0, h[31:8]}) - (longint'(1) << 24);
  endfunction

  function automatic longint lerp_q(longint a, longint b, longint w);
    return a + fshift((b - a) * w, 16);
  endfunction

  function automatic logic [OUT_W-1:0] noise_of(point_t p, logic [31:0] base_seed);
    longint scales[4];
    longint pos[3];
    logic [31:0] lat_lo[3];
    logic [31:0] lat_hi[3];
    longint wt[3];
    longint s, t, t2, sum, a0, a1, b0, b1;
    logic [31:0] sd;
    scales = '{65536, 132383, 267413, 540174};
    pos[0] = longint'($signed(p.px));
    pos[1] = longint'($signed(p.py));
    pos[2] = longint'($signed(p.pz));
    sum = 0;
    for (int i = 0; i < 4; i++) begin
      sd = base_seed ^ (32'h9E3779B9 * (i + 1));
      for (int d = 0; d < 3; d++) begin
        s = fshift(pos[d] * scales[i], 16);
        lat_lo[d] = s[47:16];
        lat_hi[d] = lat_lo[d] + 32'd1;
        t = s & 64'hFFFF;
        t2 = (t * t) >>> 16;
        wt[d] = (t2 * ((longint'(3) << 16) - 2 * t)) >>> 16;
      end
      a0 = lerp_q(lattice_value(lat_lo[0], lat_lo[1], lat_lo[2], sd),
                  lattice_value(lat_hi[0], lat_lo[1], lat_lo[2], sd), wt[0]);
      a1 = lerp_q(lattice_value(lat_lo[0], lat_hi[1], lat_lo[2], sd),
                  lattice_value(lat_hi[0], lat_hi[1], lat_lo[2], sd), wt[0]);
      b0 = lerp_q(lattice_value(lat_lo[0], lat_lo[1], lat_hi[2], sd),
                  lattice_value(lat_hi[0], lat_lo[1], lat_hi[2], sd), wt[0]);
      b1 = lerp_q(lattice_value(lat_lo[0], lat_hi[1], lat_hi[2], sd),
                  lattice_value(lat_hi[0], lat_hi[1], lat_hi[2], sd), wt[0]);
      sum += fshift(lerp_q(lerp_q(a0, a1, wt[1]), lerp_q(b0, b1, wt[1]), wt[2]), i + 1);
    end
    sum = fshift(sum, 8);
    if (sum > 131071) sum = 131071;
    if (sum < -131072) sum = -131072;
    return sum[OUT_W-1:0];
  endfunction

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return $urandom;
      1: return 32'(int'($urandom_range(0, 2000000)) - 1000000);
      2: return {$urandom_range(0, 1) ? 16'hFFFF : 16'h0000, 16'($urandom)};
      3: return $urandom_range(0, 1) ? 32'h7FFF0000 + $urandom_range(0, 65535)
                                      : 32'h80000000 + $urandom_range(0, 65535);
      4: return 32'(int'($urandom_range(0, 400)) - 200) << 16;
      default: return 32'(int'($urandom_range(0, 131072)) - 65536);
    endcase
  endfunction

  task automatic add_point(logic [31:0] x, logic [31:0] y, logic [31:0] z);
    point_t p;
    p.px = x;
    p.py = y;
    p.pz = z;
    pending_points.insert(pending_points.size(), p);
  endtask

  task automatic apb_write(logic [2:0] addr, logic [31:0] data);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= addr;
    cfg_pwdata <= data;
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
    if (addr == ADDR_SEED) seed_model = data;
  endtask

  task automatic drain();
    while (pending_points.size() != 0 || expected_noise.size() != 0 || in_valid)
      @(posedge clk);
    repeat (PIPE_LAT + 10) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        expected_noise.insert(expected_noise.size(),
                              noise_of('{in_pos_x, in_pos_y, in_pos_z}, seed_model));
      end
      if ((!in_valid || in_ready) && pending_points.size() != 0 &&
          (quiet_mode || $urandom_range(0, 99) >= 23)) begin
        point_t p;
        p = pending_points.pop_front();
        in_pos_x <= p.px;
        in_pos_y <= p.py;
        in_pos_z <= p.pz;
        in_valid <= 1'b1;
      end else if (in_valid && in_ready) begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_noise.size() == 0) begin
          $display("%0t: unexpected transfer, actual %0d", $time, out_noise_value);
          errors++;
        end else begin
          logic [OUT_W-1:0] e;
          e = expected_noise.pop_front();
          if (e !== out_noise_value) begin
            $display("%0t: noise_value expected %0d actual %0d", $time,
                     $signed(e), out_noise_value);
            errors++;
          end
        end
      end
      if (hold_count > 0) begin
        hold_count--;
        out_ready <= 1'b0;
      end else begin
        out_ready <= quiet_mode || $urandom_range(0, 99) >= 23;
      end
    end
  end

  initial begin
    #20_000_000;
    $display("fbm_value_noise_3d_unit test failed");
    $finish;
  end

  initial begin
    logic [31:0] seeds[5];
    errors = 0;
    hold_count = 0;
    quiet_mode = 0;
    seed_model = 32'd0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_pos_x = '0;
    in_pos_y = '0;
    in_pos_z = '0;
    out_ready = 1'b0;
    cfg_psel = 1'b0;
    cfg_penable = 1'b0;
    cfg_pwrite = 1'b0;
    cfg_paddr = '0;
    cfg_pwdata = '0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    add_point(32'h0, 32'h0, 32'h0);
    add_point(32'h7FFFFFFF, 32'h7FFFFFFF, 32'h7FFFFFFF);
    add_point(32'h80000000, 32'h80000000, 32'h80000000);
    add_point(32'hFFFFFFFF, 32'h00000001, 32'h0000FFFF);
    add_point(32'h00010000, 32'hFFFF0000, 32'h00008000);
    add_point(32'h7FFFFFFF, 32'h80000000, 32'h0);
    add_point(32'h80000000, 32'h7FFFFFFF, 32'hFFFFFFFF);
    add_point(32'h0000FFFF, 32'h0000FFFF, 32'h0000FFFF);
    add_point(32'h55555555, 32'hAAAAAAAA, 32'h12345678);
    add_point(32'hAAAAAAAA, 32'h55555555, 32'hEDCBA987);
    drain();

    seeds = '{32'hFFFFFFFF, 32'h0, 32'h9E3779B9, $urandom, $urandom};
    apb_write(ADDR_BAD, 32'hDEADBEEF);
    for (int ph = 0; ph < 5; ph++) begin
      apb_write(ADDR_SEED, seeds[ph]);
      add_point(32'h0, 32'h0, 32'h0);
      add_point(32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF);
      for (int n = 0; n < 340; n++) add_point(rand_coord(), rand_coord(), rand_coord());
      if (ph == 1) begin
        quiet_mode = 1;
        repeat (400) @(posedge clk);
        quiet_mode = 0;
      end
      if (ph == 2) begin
        repeat (20) @(posedge clk);
        hold_count = 300;
      end
      drain();
    end

    if (errors == 0 && expected_noise.size() == 0) begin
      $display("fbm_value_noise_3d_unit test passed");
    end else begin
      $display("fbm_value_noise_3d_unit test failed");
    end
    $finish;
  end
endmodule
